[src/cjd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cjd_pkg
// Shared types, timing constants, reciprocal constants and small lookup
// functions for the calendar / Julian day converter.
// ----------------------------------------------------------------------------
package cjd_pkg;

  // Time base
  localparam logic [63:0] TICKS_PER_SECOND = 64'd1000000;
  localparam logic [63:0] MIN_TICKS        = 64'd60 * TICKS_PER_SECOND;
  localparam logic [63:0] HOUR_TICKS       = 64'd3600 * TICKS_PER_SECOND;
  localparam logic [63:0] DAY_TICKS        = 64'd86400 * TICKS_PER_SECOND;
  localparam logic [63:0] HALF_DAY_TICKS   = 64'd43200 * TICKS_PER_SECOND;
  // seconds above 59.9999 round up
  localparam logic [63:0] ROUND_LIM        = (64'd599999 * TICKS_PER_SECOND) / 64'd10000;

  // First accepted Julian day number (1801-01-01 starts in its second half)
  localparam logic [24:0] JD_FIRST = 25'd2378861;

  // Pipeline depth shared by both datapaths
  localparam int NSTG = 18;

  // Action codes
  localparam logic ACT_TO_JD  = 1'b0;
  localparam logic ACT_TO_CAL = 1'b1;

  // Reciprocals for constant division: q0 = (x * K) >> N, then one correction
  localparam int          HN   = 37;
  localparam logic [63:0] KH   = (64'd1 << HN) / HOUR_TICKS;
  localparam int          KH_W = $clog2(KH + 64'd1);
  localparam int          MN   = 32;
  localparam logic [63:0] KM   = (64'd1 << MN) / MIN_TICKS;
  localparam int          KM_W = $clog2(KM + 64'd1);
  localparam int          NN   = 28;
  localparam logic [63:0] KN   = (64'd1 << NN) / 64'd146097;
  localparam int          KN_W = $clog2(KN + 64'd1);
  localparam int          YN   = 28;
  localparam logic [63:0] KY   = (64'd1 << YN) / 64'd1461001;
  localparam int          KY_W = $clog2(KY + 64'd1);
  localparam int          CN   = 17;
  localparam logic [63:0] KC   = (64'd1 << CN) / 64'd100;
  localparam int          KC_W = $clog2(KC + 64'd1);

  typedef struct packed {
    logic        action;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [25:0] second_ticks;
    logic [24:0] jd_whole;
    logic [36:0] jd_fraction;
  } cjd_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [16:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [25:0] out_second;
    logic [24:0] out_jd_whole;
    logic [36:0] out_jd_fraction;
  } cjd_out_t;

  // 367 * (m - 2 + 12a) / 12 for m = 1..12
  function automatic logic [8:0] doy_base(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd336;
      4'd2:    r = 9'd367;
      4'd3:    r = 9'd30;
      4'd4:    r = 9'd61;
      4'd5:    r = 9'd91;
      4'd6:    r = 9'd122;
      4'd7:    r = 9'd152;
      4'd8:    r = 9'd183;
      4'd9:    r = 9'd214;
      4'd10:   r = 9'd244;
      4'd11:   r = 9'd275;
      4'd12:   r = 9'd305;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // 2447 * m / 80
  function automatic logic [9:0] mon_start(input logic [3:0] m);
    logic [9:0] r;
    case (m)
      4'd1:    r = 10'd30;
      4'd2:    r = 10'd61;
      4'd3:    r = 10'd91;
      4'd4:    r = 10'd122;
      4'd5:    r = 10'd152;
      4'd6:    r = 10'd183;
      4'd7:    r = 10'd214;
      4'd8:    r = 10'd244;
      4'd9:    r = 10'd275;
      4'd10:   r = 10'd305;
      4'd11:   r = 10'd336;
      4'd12:   r = 10'd367;
      4'd13:   r = 10'd397;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  // 80 * l / 2447 for the small range of l seen here
  function automatic logic [3:0] month_of(input logic [9:0] l);
    logic [3:0] r;
    if      (l >= 10'd398) r = 4'd13;
    else if (l >= 10'd368) r = 4'd12;
    else if (l >= 10'd337) r = 4'd11;
    else if (l >= 10'd306) r = 4'd10;
    else if (l >= 10'd276) r = 4'd9;
    else if (l >= 10'd245) r = 4'd8;
    else if (l >= 10'd215) r = 4'd7;
    else if (l >= 10'd184) r = 4'd6;
    else if (l >= 10'd153) r = 4'd5;
    else if (l >= 10'd123) r = 4'd4;
    else if (l >= 10'd92)  r = 4'd3;
    else if (l >= 10'd62)  r = 4'd2;
    else if (l >= 10'd31)  r = 4'd1;
    else                   r = 4'd0;
    return r;
  endfunction

endpackage
`default_nettype wire

[src/calendar_julian_day_converter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_julian_day_converter
// Gregorian date/time <-> Julian day number plus microsecond day fraction.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------
//  in      | in_valid_i / in_ready_o   | in_data_i  (cjd_in_t)
//  out     | out_valid_o / out_ready_i | out_data_o (cjd_out_t)
//
// Results leave in input order; one transaction per cycle unless the pipeline is full and the output stalls.
// Pipeline depth is set by the date formulas in the reverse path (chained constant
// divisions, each a reciprocal multiply plus a correction stage).
// Reset clears only the stage valid bits; no clearing pass.
// A stage advances when it or any later stage is empty or the output is taken,
// so bubbles are squeezed out during a stall and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module calendar_julian_day_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cjd_pkg::cjd_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cjd_pkg::cjd_out_t  out_data_o
);

  logic [cjd_pkg::NSTG-1:0] vld_q;
  logic [cjd_pkg::NSTG-1:0] en;
  cjd_pkg::cjd_out_t        jd_res, cal_res;

  for (genvar g = 0; g < cjd_pkg::NSTG; g++) begin : g_en
    assign en[g] = out_ready_i | ~(&vld_q[cjd_pkg::NSTG-1:g]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < cjd_pkg::NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  cjd_to_jd u_to_jd (
    .clk_i (clk_i),
    .en_i  (en),
    .in_i  (in_data_i),
    .res_o (jd_res)
  );

  cjd_to_cal u_to_cal (
    .clk_i (clk_i),
    .en_i  (en),
    .in_i  (in_data_i),
    .res_o (cal_res)
  );

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[cjd_pkg::NSTG-1];
  // each path zeroes its result unless it owns a valid transaction
  assign out_data_o  = jd_res | cal_res;

endmodule
`default_nettype wire

[src/cjd_to_jd.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cjd_to_jd
// Calendar date/time to Julian day datapath. Five working stages, then a
// delay line up to the shared pipeline depth. Output is zero unless valid.
// ----------------------------------------------------------------------------
module cjd_to_jd (
  input  logic                       clk_i,
  input  logic [cjd_pkg::NSTG-1:0]   en_i,
  input  cjd_pkg::cjd_in_t           in_i,
  output cjd_pkg::cjd_out_t          res_o
);

  localparam int CN_P = cjd_pkg::CN;
  localparam int KC_P = cjd_pkg::KC_W;

  typedef struct packed {
    logic        ok;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [25:0] second;
  } dt_t;

  dt_t keep_q [0:3];
  dt_t keep_d0, keep_d3;
  logic e0_q, e0_d;

  // stage 1
  logic [16:0]          u1, v1;
  logic [16:0]          v1_q;
  logic [CN_P+KC_P-1:0] pv1_q, py1_q;
  logic [26:0]          a1_q;
  logic [36:0]          th1_q;
  logic [31:0]          tm1_q;
  // stage 2
  logic [9:0]  vq2, yq2, vq2_q, yq2_q;
  logic [16:0] vp2_q, yp2_q, v2_q;
  logic [26:0] a2_q;
  logic [36:0] ts2_q;
  // stage 3
  logic [16:0] vr3, yr3;
  logic [9:0]  yqc3, c3_q;
  logic        leap3, neg3_q;
  logic [36:0] t3_d, t3_q;
  logic [26:0] a3_q;
  // stage 4 and delay
  logic [26:0]       jd4;
  cjd_pkg::cjd_out_t res4_d;
  cjd_pkg::cjd_out_t res_q [4:cjd_pkg::NSTG-1];

  always_comb begin
    logic thirty;
    thirty = in_i.month == 4'd4 || in_i.month == 4'd6 ||
             in_i.month == 4'd9 || in_i.month == 4'd11;
    keep_d0.ok     = in_i.action == cjd_pkg::ACT_TO_JD &&
                     in_i.month >= 4'd1 && in_i.month <= 4'd12 &&
                     in_i.day >= 5'd1 && !(thirty && in_i.day > 5'd30) &&
                     in_i.hour <= 5'd23 && in_i.minute <= 6'd59 &&
                     in_i.second_ticks < 26'(cjd_pkg::MIN_TICKS) &&
                     in_i.year >= 16'd1801;
    keep_d0.year   = in_i.year;
    keep_d0.month  = in_i.month;
    keep_d0.day    = in_i.day;
    keep_d0.hour   = in_i.hour;
    keep_d0.minute = in_i.minute;
    keep_d0.second = in_i.second_ticks;
    e0_d           = in_i.month <= 4'd2;
  end

  assign u1 = 17'(keep_q[0].year) + 17'd4800 - 17'(e0_q);
  assign v1 = 17'(keep_q[0].year) + 17'd4900 - 17'(e0_q);

  assign vq2 = pv1_q[CN_P+9:CN_P];
  assign yq2 = py1_q[CN_P+9:CN_P];

  // century terms with remainder correction, leap year, noon shift
  always_comb begin
    logic feb_bad;
    vr3  = v2_q - vp2_q;
    yr3  = 17'(keep_q[2].year) - yp2_q;
    yqc3 = yq2_q;
    if (yr3 >= 17'd100) begin
      yr3  = yr3 - 17'd100;
      yqc3 = yq2_q + 10'd1;
    end
    leap3 = (keep_q[2].year[1:0] == 2'b00 && yr3 != 17'd0) ||
            (yr3 == 17'd0 && yqc3[1:0] == 2'b00);
    feb_bad = keep_q[2].month == 4'd2 &&
              keep_q[2].day > (leap3 ? 5'd29 : 5'd28);
    keep_d3    = keep_q[2];
    keep_d3.ok = keep_q[2].ok && !feb_bad;
    if (ts2_q >= 37'(cjd_pkg::HALF_DAY_TICKS)) begin
      t3_d = ts2_q - 37'(cjd_pkg::HALF_DAY_TICKS);
    end else begin
      t3_d = ts2_q + 37'(cjd_pkg::HALF_DAY_TICKS);
    end
  end

  always_comb begin
    jd4 = 27'(keep_q[3].day) + 27'(a3_q >> 2) + 27'(cjd_pkg::doy_base(keep_q[3].month))
          - 27'((12'(c3_q) * 12'd3) >> 2) - 27'd32075 - 27'(neg3_q);
    res4_d = '0;
    if (keep_q[3].ok) begin
      res4_d.valid_res       = 1'b1;
      res4_d.out_year        = 17'(keep_q[3].year);
      res4_d.out_month       = keep_q[3].month;
      res4_d.out_day         = keep_q[3].day;
      res4_d.out_hour        = keep_q[3].hour;
      res4_d.out_minute      = keep_q[3].minute;
      res4_d.out_second      = keep_q[3].second;
      res4_d.out_jd_whole    = jd4[24:0];
      res4_d.out_jd_fraction = t3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      keep_q[0] <= keep_d0;
      e0_q      <= e0_d;
    end
    if (en_i[1]) begin
      keep_q[1] <= keep_q[0];
      v1_q      <= v1;
      pv1_q     <= (CN_P+KC_P)'(v1) * (CN_P+KC_P)'(cjd_pkg::KC);
      py1_q     <= (CN_P+KC_P)'(keep_q[0].year) * (CN_P+KC_P)'(cjd_pkg::KC);
      a1_q      <= 27'(u1) * 27'd1461;
      th1_q     <= 37'(keep_q[0].hour) * 37'(cjd_pkg::HOUR_TICKS);
      tm1_q     <= 32'(keep_q[0].minute) * 32'(cjd_pkg::MIN_TICKS);
    end
    if (en_i[2]) begin
      keep_q[2] <= keep_q[1];
      vq2_q     <= vq2;
      yq2_q     <= yq2;
      vp2_q     <= 17'(vq2) * 17'd100;
      yp2_q     <= 17'(yq2) * 17'd100;
      v2_q      <= v1_q;
      a2_q      <= a1_q;
      ts2_q     <= th1_q + 37'(tm1_q) + 37'(keep_q[1].second);
    end
    if (en_i[3]) begin
      keep_q[3] <= keep_d3;
      c3_q      <= (vr3 >= 17'd100) ? vq2_q + 10'd1 : vq2_q;
      t3_q      <= t3_d;
      neg3_q    <= ts2_q < 37'(cjd_pkg::HALF_DAY_TICKS);
      a3_q      <= a2_q;
    end
    if (en_i[4]) begin
      res_q[4] <= res4_d;
    end
    for (int k = 5; k < cjd_pkg::NSTG; k++) begin
      if (en_i[k]) begin
        res_q[k] <= res_q[k-1];
      end
    end
  end

  assign res_o = res_q[cjd_pkg::NSTG-1];

endmodule
`default_nettype wire

[src/cjd_to_cal.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cjd_to_cal
// Julian day to calendar datapath: time of day split, seconds round-up,
// then the integer date formulas, one constant division per few stages.
// Output is zero unless valid.
// ----------------------------------------------------------------------------
module cjd_to_cal (
  input  logic                       clk_i,
  input  logic [cjd_pkg::NSTG-1:0]   en_i,
  input  cjd_pkg::cjd_in_t           in_i,
  output cjd_pkg::cjd_out_t          res_o
);

  localparam int HN_P = cjd_pkg::HN;
  localparam int MN_P = cjd_pkg::MN;
  localparam int NN_P = cjd_pkg::NN;
  localparam int YN_P = cjd_pkg::YN;
  localparam int PH_W = HN_P + cjd_pkg::KH_W;
  localparam int PM_W = MN_P + cjd_pkg::KM_W;
  localparam int PN_W = NN_P + cjd_pkg::KN_W;
  localparam int PY_W = YN_P + cjd_pkg::KY_W;

  typedef struct packed {
    logic        ok;
    logic [24:0] jw;
    logic [36:0] jf;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [25:0] second;
  } keep_t;

  keep_t keep_q  [0:cjd_pkg::NSTG-2];
  keep_t keep_nx [1:cjd_pkg::NSTG-2];
  keep_t keep_d0;

  logic [36:0]     t0_d, t0_q, t1_q, t2_q;
  logic [PH_W-1:0] ph1_q;
  logic [4:0]      hq2, hq2_q, h3_d;
  logic [37:0]     hp2_q, rh3;
  logic [31:0]     r3_d, r3_q, r4_q, r5_q, rm6;
  logic [PM_W-1:0] pm4_q;
  logic [5:0]      mq5, mq5_q, mi6_d;
  logic [31:0]     mp5_q;
  logic [25:0]     lx7_d, lx7_q, lx8_q, lx9_q;
  logic            day_carry7;
  logic [PN_W-1:0] pn8_q;
  logic [9:0]      nq9, nq9_q, nx10_d, nx10_q;
  logic [27:0]     np9_q, rn10;
  logic [15:0]     lx2_10_q, lx2_11_q, lx2_12_q, lx2_13_q, lx2_14_q;
  logic [27:0]     x11_q, x12_q, x13_q, ry14;
  logic [16:0]     cy11_q, cy12_q, cy13_q, cy14_q, cy15_q, cy16_q;
  logic [PY_W-1:0] py12_q;
  logic [6:0]      yq13, yq13_q, y14_q, y15_q, y16_q;
  logic [27:0]     yp13_q;
  logic [17:0]     q15;
  logic [9:0]      lx3_15_q, lx3_16_q;
  logic [3:0]      m16_q;
  cjd_pkg::cjd_out_t res_d, res_q;

  // stage 0: range check and shift of the fraction to midnight
  always_comb begin
    logic [37:0] tsh;
    tsh = {1'b0, in_i.jd_fraction} + 38'(cjd_pkg::HALF_DAY_TICKS);
    t0_d = (tsh >= 38'(cjd_pkg::DAY_TICKS)) ?
           37'(tsh - 38'(cjd_pkg::DAY_TICKS)) : tsh[36:0];
    keep_d0    = '0;
    keep_d0.ok = in_i.action == cjd_pkg::ACT_TO_CAL &&
                 in_i.jd_fraction < 37'(cjd_pkg::DAY_TICKS) &&
                 in_i.jd_whole >= cjd_pkg::JD_FIRST &&
                 !(in_i.jd_whole == cjd_pkg::JD_FIRST &&
                   in_i.jd_fraction < 37'(cjd_pkg::HALF_DAY_TICKS));
    keep_d0.jw = in_i.jd_whole;
    keep_d0.jf = in_i.jd_fraction;
  end

  assign hq2 = ph1_q[HN_P+4:HN_P];
  assign mq5 = pm4_q[MN_P+5:MN_P];
  assign nq9 = pn8_q[NN_P+9:NN_P];
  assign yq13 = py12_q[YN_P+6:YN_P];

  // hour correction
  always_comb begin
    rh3  = {1'b0, t2_q} - hp2_q;
    h3_d = hq2_q;
    r3_d = rh3[31:0];
    if (rh3 >= 38'(cjd_pkg::HOUR_TICKS)) begin
      h3_d = hq2_q + 5'd1;
      r3_d = 32'(rh3 - 38'(cjd_pkg::HOUR_TICKS));
    end
  end

  // minute correction
  always_comb begin
    rm6   = r5_q - mp5_q;
    mi6_d = mq5_q;
    if (rm6 >= 32'(cjd_pkg::MIN_TICKS)) begin
      mi6_d = mq5_q + 6'd1;
      rm6   = rm6 - 32'(cjd_pkg::MIN_TICKS);
    end
  end

  // carry of the per-item fields, with updates at hour, minute and round-up
  always_comb begin
    logic rnd, rmi;
    for (int k = 1; k < cjd_pkg::NSTG - 1; k++) begin
      keep_nx[k] = keep_q[k-1];
    end
    keep_nx[3].hour   = h3_d;
    keep_nx[6].minute = mi6_d;
    keep_nx[6].second = rm6[25:0];
    // round-up past 59.9999 s; a carry out of the day moves the date by one
    rnd        = keep_q[6].second > 26'(cjd_pkg::ROUND_LIM);
    rmi        = rnd && keep_q[6].minute == 6'd59;
    day_carry7 = rmi && keep_q[6].hour == 5'd23;
    if (rnd) begin
      keep_nx[7].second = '0;
      keep_nx[7].minute = rmi ? 6'd0 : keep_q[6].minute + 6'd1;
    end
    if (rmi) begin
      keep_nx[7].hour = day_carry7 ? 5'd0 : keep_q[6].hour + 5'd1;
    end
    lx7_d = 26'(keep_q[6].jw) + 26'(keep_q[6].hour < 5'd12) + 26'(day_carry7)
            + 26'd68569;
  end

  // 4*lx / 146097 correction; lx - (146097*n + 3)/4 equals remainder / 4
  always_comb begin
    rn10   = {lx9_q, 2'b00} - np9_q;
    nx10_d = nq9_q;
    if (rn10 >= 28'd146097) begin
      nx10_d = nq9_q + 10'd1;
      rn10   = rn10 - 28'd146097;
    end
  end

  assign ry14 = x13_q - yp13_q;
  assign q15  = 18'(y14_q) * 18'd1461;

  always_comb begin
    logic        carry;
    logic [16:0] yr;
    logic [3:0]  mo;
    logic [9:0]  dd;
    carry = m16_q >= 4'd11;
    mo    = 4'(m16_q + 4'd2 - (carry ? 4'd12 : 4'd0));
    dd    = lx3_16_q - cjd_pkg::mon_start(m16_q);
    yr    = cy16_q + 17'(y16_q) + 17'(carry);
    res_d = '0;
    if (keep_q[16].ok) begin
      res_d.valid_res       = 1'b1;
      res_d.out_year        = yr;
      res_d.out_month       = mo;
      res_d.out_day         = dd[4:0];
      res_d.out_hour        = keep_q[16].hour;
      res_d.out_minute      = keep_q[16].minute;
      res_d.out_second      = keep_q[16].second;
      res_d.out_jd_whole    = keep_q[16].jw;
      res_d.out_jd_fraction = keep_q[16].jf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      keep_q[0] <= keep_d0;
      t0_q      <= t0_d;
    end
    for (int k = 1; k < cjd_pkg::NSTG - 1; k++) begin
      if (en_i[k]) begin
        keep_q[k] <= keep_nx[k];
      end
    end
    if (en_i[1]) begin
      t1_q  <= t0_q;
      ph1_q <= PH_W'(t0_q) * PH_W'(cjd_pkg::KH);
    end
    if (en_i[2]) begin
      t2_q  <= t1_q;
      hq2_q <= hq2;
      hp2_q <= 38'(hq2) * 38'(cjd_pkg::HOUR_TICKS);
    end
    if (en_i[3]) begin
      r3_q <= r3_d;
    end
    if (en_i[4]) begin
      r4_q  <= r3_q;
      pm4_q <= PM_W'(r3_q) * PM_W'(cjd_pkg::KM);
    end
    if (en_i[5]) begin
      r5_q  <= r4_q;
      mq5_q <= mq5;
      mp5_q <= 32'(mq5) * 32'(cjd_pkg::MIN_TICKS);
    end
    if (en_i[7]) begin
      lx7_q <= lx7_d;
    end
    if (en_i[8]) begin
      lx8_q <= lx7_q;
      pn8_q <= PN_W'({lx7_q, 2'b00}) * PN_W'(cjd_pkg::KN);
    end
    if (en_i[9]) begin
      lx9_q <= lx8_q;
      nq9_q <= nq9;
      np9_q <= 28'(nq9) * 28'd146097;
    end
    if (en_i[10]) begin
      nx10_q   <= nx10_d;
      lx2_10_q <= rn10[17:2];
    end
    if (en_i[11]) begin
      x11_q    <= 28'(17'(lx2_10_q) + 17'd1) * 28'd4000;
      cy11_q   <= 17'(nx10_q - 10'd49) * 17'd100;
      lx2_11_q <= lx2_10_q;
    end
    if (en_i[12]) begin
      py12_q   <= PY_W'(x11_q) * PY_W'(cjd_pkg::KY);
      x12_q    <= x11_q;
      lx2_12_q <= lx2_11_q;
      cy12_q   <= cy11_q;
    end
    if (en_i[13]) begin
      yq13_q   <= yq13;
      yp13_q   <= 28'(yq13) * 28'd1461001;
      x13_q    <= x12_q;
      lx2_13_q <= lx2_12_q;
      cy13_q   <= cy12_q;
    end
    if (en_i[14]) begin
      y14_q    <= (ry14 >= 28'd1461001) ? yq13_q + 7'd1 : yq13_q;
      lx2_14_q <= lx2_13_q;
      cy14_q   <= cy13_q;
    end
    if (en_i[15]) begin
      lx3_15_q <= 10'(17'(lx2_14_q) + 17'd31 - 17'(q15 >> 2));
      y15_q    <= y14_q;
      cy15_q   <= cy14_q;
    end
    if (en_i[16]) begin
      m16_q    <= cjd_pkg::month_of(lx3_15_q);
      lx3_16_q <= lx3_15_q;
      y16_q    <= y15_q;
      cy16_q   <= cy15_q;
    end
    if (en_i[17]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

[src/cjd_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cjd_checker
// Port-level checks for the converter, attached by bind.
// ----------------------------------------------------------------------------
module cjd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input cjd_pkg::cjd_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.valid_res |-> out_data_o == '0)
    else $error("rejected result has nonzero fields");

  a_fields_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.valid_res |->
      out_data_o.out_hour <= 5'd23 && out_data_o.out_minute <= 6'd59 &&
      out_data_o.out_month >= 4'd1 && out_data_o.out_month <= 4'd12 &&
      out_data_o.out_day >= 5'd1)
    else $error("valid result outside calendar range");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

endmodule

bind calendar_julian_day_converter cjd_checker u_cjd_checker (.*);
`default_nettype wire
